>>> rtl/dnsab_pkg.sv
// ============================================================================
// dnsab_pkg
// Shared types, constants and byte tables for the DNS A-record response
// builder.
// ============================================================================
package dnsab_pkg;

   localparam int unsigned QueueDepthDefault = 4;
   localparam logic [31:0] TtlReset          = 32'd60;
   localparam logic [3:0]  HeaderLastPos     = 4'd11;
   localparam logic [2:0]  TailLen           = 3'd4;
   localparam logic [4:0]  AnswerLen         = 5'd16;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_NAME   = 2'd1,
      PH_TAIL   = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_SHORT_HEADER  = 2'd1,
      ST_NO_TERMINATOR = 2'd2,
      ST_TRUNCATED     = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]  query_byte;
      logic        last_byte;
      logic        name_found;
      logic [31:0] ipv4_addr;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_response;
      logic [1:0] status;
   } rsp_type;

   // One classified query byte, handed from the parser to the emitter.
   typedef struct packed {
      logic        has_byte;
      logic [7:0]  data;
      logic        last;
      logic        answer;
      status_type  status;
      logic [31:0] addr;
   } cmd_type;

   // Rewritten header byte at a given header position.
   function automatic logic [7:0] header_byte(input logic [3:0] pos,
                                              input logic [7:0] b,
                                              input logic       found);
      logic [7:0] r;
      case (pos)
         4'd0, 4'd1: r = b;
         4'd2:       r = 8'h81;
         4'd3:       r = found ? 8'h80 : 8'h83;
         4'd5:       r = 8'h01;
         4'd7:       r = {7'd0, found};
         default:    r = 8'h00;
      endcase
      return r;
   endfunction

   // Byte of the 16-byte A answer record at a given index.
   function automatic logic [7:0] answer_byte(input logic [3:0]  idx,
                                              input logic [31:0] ttl,
                                              input logic [31:0] addr);
      logic [7:0] r;
      case (idx)
         4'd0:    r = 8'hc0;
         4'd1:    r = 8'h0c;
         4'd3:    r = 8'h01;
         4'd5:    r = 8'h01;
         4'd6:    r = ttl[31:24];
         4'd7:    r = ttl[23:16];
         4'd8:    r = ttl[15:8];
         4'd9:    r = ttl[7:0];
         4'd11:   r = 8'h04;
         4'd12:   r = addr[31:24];
         4'd13:   r = addr[23:16];
         4'd14:   r = addr[15:8];
         4'd15:   r = addr[7:0];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/dns_a_response_builder.sv
// A query word reaches the response port through the queue, cmd_ff and rsp_data_ff.
// Throughput: one query word per cycle unless the queue is full, and one response
// word per cycle while rsp_ready holds. A final word with an answer adds 16 response
// words, while the queue takes up to QueueDepth more query words; then input stalls.
// Reset (synchronous, active high) returns the parser to the header phase,
// empties the queue, drops any pending response and sets the TTL to 60.
// ============================================================================
// dns_a_response_builder
// Builds a DNS A-record response from a query streamed in one byte per word.
// ============================================================================
module dns_a_response_builder #(
   parameter int unsigned QueueDepth = dnsab_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dnsab_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dnsab_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   // Answer TTL register; the user must write it only while the block is idle,
   // which the block itself does not enforce, so the emitter reads it directly.
   logic [31:0] ttl_ff;

   dnsab_pkg::cmd_type push_cmd, pop_cmd;
   logic               push, full, pop, not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= dnsab_pkg::TtlReset;
      end else if (csr_wr_en) begin
         ttl_ff <= csr_wr_data;
      end
   end

   // Front: parse and classify each query word. It stalls only when the
   // queue is full.
   dnsab_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (push),
      .q_cmd     (push_cmd),
      .q_full    (full)
   );

   // Queue: decouples the parser from the answer bursts of the emitter.
   dnsab_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .not_empty (not_empty)
   );

   // Back: emit the words, append the answer and hold the output register.
   dnsab_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (not_empty),
      .q_cmd      (pop_cmd),
      .q_pop      (pop),
      .answer_ttl (ttl_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/dnsab_front.sv
// ============================================================================
// dnsab_front
// Query parser: tracks header, name and tail phases and turns each accepted
// query word, apart from dropped non-final ones, into a command for the emitter.
// ============================================================================
module dnsab_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dnsab_pkg::req_type req_data,
   output logic              q_push,
   output dnsab_pkg::cmd_type q_cmd,
   input  logic              q_full
);

   dnsab_pkg::phase_type phase_ff, phase_in;
   logic [3:0] hpos_ff, hpos_in;
   logic [2:0] tail_ff, tail_in;
   logic       accept;
   logic [2:0] tail_dec;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign tail_dec  = (tail_ff == 3'd0) ? 3'd0 : tail_ff - 3'd1;

   always_comb begin
      phase_in        = phase_ff;
      hpos_in         = hpos_ff;
      tail_in         = tail_ff;
      q_cmd.has_byte  = 1'b1;
      q_cmd.data      = req_data.query_byte;
      q_cmd.last      = req_data.last_byte;
      q_cmd.status    = dnsab_pkg::ST_OK;
      q_cmd.addr      = req_data.ipv4_addr;
      case (phase_ff)
         dnsab_pkg::PH_HEADER: begin
            q_cmd.data = dnsab_pkg::header_byte(hpos_ff, req_data.query_byte,
                                                req_data.name_found);
            if (hpos_ff >= dnsab_pkg::HeaderLastPos) begin
               phase_in     = dnsab_pkg::PH_NAME;
               hpos_in      = 4'd0;
               q_cmd.status = dnsab_pkg::ST_NO_TERMINATOR;
            end else begin
               hpos_in      = hpos_ff + 4'd1;
               q_cmd.status = dnsab_pkg::ST_SHORT_HEADER;
            end
         end
         dnsab_pkg::PH_NAME: begin
            if (req_data.query_byte == 8'd0) begin
               phase_in     = dnsab_pkg::PH_TAIL;
               tail_in      = dnsab_pkg::TailLen;
               q_cmd.status = dnsab_pkg::ST_TRUNCATED;
            end else begin
               q_cmd.status = dnsab_pkg::ST_NO_TERMINATOR;
            end
         end
         dnsab_pkg::PH_TAIL: begin
            tail_in = tail_dec;
            if (tail_dec == 3'd0) begin
               phase_in = dnsab_pkg::PH_DONE;
            end else begin
               q_cmd.status = dnsab_pkg::ST_TRUNCATED;
            end
         end
         default: begin
            // drop bytes past the question
            q_cmd.has_byte = 1'b0;
         end
      endcase
      q_cmd.answer = req_data.last_byte && req_data.name_found &&
                     (q_cmd.status == dnsab_pkg::ST_OK);
      if (req_data.last_byte) begin
         phase_in = dnsab_pkg::PH_HEADER;
         hpos_in  = 4'd0;
         tail_in  = 3'd0;
      end
   end

   // a dropped, non-final word produces nothing downstream
   assign q_push = accept && (q_cmd.has_byte || req_data.last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dnsab_pkg::PH_HEADER;
         hpos_ff  <= 4'd0;
         tail_ff  <= 3'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hpos_ff  <= hpos_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

>>> rtl/dnsab_fifo.sv
// ============================================================================
// dnsab_fifo
// Short command queue between parser and emitter.
// ============================================================================
module dnsab_fifo #(
   parameter int unsigned Depth = dnsab_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dnsab_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output dnsab_pkg::cmd_type pop_data,
   output logic               not_empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   dnsab_pkg::cmd_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == CntFull);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/dnsab_back.sv
// ============================================================================
// dnsab_back
// Emitter: plays out each command as response words, appends the A answer
// when the command carries one and drives the registered response channel.
// ============================================================================
module dnsab_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  dnsab_pkg::cmd_type q_cmd,
   output logic               q_pop,
   input  logic [31:0]        answer_ttl,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dnsab_pkg::rsp_type rsp_data
);

   dnsab_pkg::cmd_type cmd_ff;
   logic               head_ff, head_in;
   logic [4:0]         ans_ff, ans_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dnsab_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               active, out_free, emit, finish, load;
   logic [4:0]         ans_idx;

   assign active   = head_ff || (ans_ff != 5'd0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = active && out_free;
   assign finish   = emit && (head_ff ? (ans_ff == 5'd0) : (ans_ff == 5'd1));
   assign load     = q_valid && (!active || finish);
   assign q_pop    = load;
   assign ans_idx  = dnsab_pkg::AnswerLen - ans_ff;

   always_comb begin
      head_in      = head_ff;
      ans_in       = ans_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (head_ff) begin
            // query byte, or a bare end marker
            head_in                     = 1'b0;
            rsp_data_in.out_byte        = cmd_ff.has_byte ? cmd_ff.data : 8'd0;
            rsp_data_in.byte_valid      = cmd_ff.has_byte;
            rsp_data_in.end_of_response = cmd_ff.last && !cmd_ff.answer;
            rsp_data_in.status          = rsp_data_in.end_of_response ?
                                          cmd_ff.status : dnsab_pkg::ST_OK;
         end else begin
            ans_in                      = ans_ff - 5'd1;
            rsp_data_in.out_byte        = dnsab_pkg::answer_byte(ans_idx[3:0],
                                                                 answer_ttl,
                                                                 cmd_ff.addr);
            rsp_data_in.byte_valid      = 1'b1;
            rsp_data_in.end_of_response = (ans_ff == 5'd1);
            rsp_data_in.status          = dnsab_pkg::ST_OK;
         end
      end
      if (load) begin
         head_in = q_cmd.has_byte || !q_cmd.answer;
         ans_in  = q_cmd.answer ? dnsab_pkg::AnswerLen : 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= 1'b0;
         ans_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         ans_ff       <= ans_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load) begin
         cmd_ff <= q_cmd;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/dnsab_checker.sv
// ============================================================================
// dnsab_checker
// Port-level checks on the response stream of the builder.
// ============================================================================
module dnsab_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input dnsab_pkg::rsp_type rsp_data
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // a bare marker only closes a response
   a_marker_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.end_of_response)
      else $error("bare marker without end of response");

   // an error status only rides on the final word
   a_status_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != dnsab_pkg::ST_OK)
         |-> rsp_data.end_of_response)
      else $error("error status before end of response");

   // drop any pending word on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind dns_a_response_builder dnsab_checker u_dnsab_checker (.*);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNS A-record response builder: streams queries
// in one byte per word, predicts the rewritten response and compares it.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] byte_list_type[$];

   // Fixed fields of the response: flags, answer record framing.
   localparam logic [15:0] FLAGS_FOUND    = 16'h8180;
   localparam logic [15:0] FLAGS_NXDOMAIN = 16'h8183;
   localparam logic [15:0] NAME_POINTER   = 16'hc00c;
   localparam logic [15:0] TYPE_A         = 16'd1;
   localparam logic [15:0] ANSWER_CLASS   = 16'd1;
   localparam logic [15:0] RDATA_LEN      = 16'd4;
   localparam int          HEADER_LEN     = 12;
   localparam int          MAX_REPLY      = 17;
   // Cycles to let the pipeline settle after the last expected word.
   localparam int          SETTLE_CYCLES  = 10;
   localparam int          DRAIN_GUARD    = 5000;
   localparam int          PRINT_LIMIT    = 20;

   logic     clock       = 1'b0;
   logic     reset       = 1'b1;
   logic     req_valid   = 1'b0;
   logic     req_ready;
   dnsab_pkg::req_type req_data = '0;
   logic     rsp_valid;
   logic     rsp_ready   = 1'b1;
   dnsab_pkg::rsp_type rsp_data;
   logic     csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // Predictor state: header index, parse phase, tail countdown, TTL register.
   logic [3:0]  hdr_pos   = '0;
   dnsab_pkg::phase_type phase = dnsab_pkg::PH_HEADER;
   logic [2:0]  tail_left = '0;
   logic [31:0] ttl_model = dnsab_pkg::TtlReset;

   dnsab_pkg::rsp_type pending_reply_words[$];

   // Traffic shaping knobs, set by the tests.
   bit ready_stalls = 1'b0;
   bit sender_gaps  = 1'b0;
   int burst_left   = 0;
   logic [15:0] stall_pattern = 16'hffff;
   int pattern_age  = 0;

   // Run statistics.
   int mismatch_count = 0;
   int words_sent     = 0;
   int queries_sent   = 0;
   int answers_built  = 0;
   int words_checked  = 0;
   int ttl_writes     = 0;

   dns_a_response_builder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs; sized well above the slowest run.
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic dnsab_pkg::rsp_type make_word(input logic [7:0] b,
                                                    input logic carries);
      dnsab_pkg::rsp_type w;
      w            = '0;
      w.out_byte   = b;
      w.byte_valid = carries;
      return w;
   endfunction

   // Rewrite one header byte: ID passes, flags and counts are replaced.
   function automatic logic [7:0] rewrite_header(input logic [3:0] pos,
                                                 input logic [7:0] b,
                                                 input logic       found);
      logic [15:0] flags;
      logic [7:0]  r;
      flags = found ? FLAGS_FOUND : FLAGS_NXDOMAIN;
      case (pos)
         4'd0, 4'd1: r = b;
         4'd2:       r = flags[15:8];
         4'd3:       r = flags[7:0];
         4'd5:       r = 8'd1;          // QDCOUNT low byte
         4'd7:       r = {7'd0, found}; // ANCOUNT low byte
         default:    r = 8'd0;
      endcase
      return r;
   endfunction

   // Advance the parser by one query word and queue the response words it
   // produces; on the final word close the response and rearm for the next.
   function automatic void predict_reply(input dnsab_pkg::req_type w);
      dnsab_pkg::rsp_type    words[MAX_REPLY];
      int                    n;
      int                    i;
      dnsab_pkg::status_type st;
      logic [127:0]          answer;
      n  = 0;
      st = dnsab_pkg::ST_OK;
      case (phase)
         dnsab_pkg::PH_HEADER: begin
            words[n] = make_word(rewrite_header(hdr_pos, w.query_byte, w.name_found),
                                 1'b1);
            n++;
            if (hdr_pos >= dnsab_pkg::HeaderLastPos) begin
               phase   = dnsab_pkg::PH_NAME;
               hdr_pos = '0;
               st      = dnsab_pkg::ST_NO_TERMINATOR;
            end else begin
               hdr_pos = hdr_pos + 4'd1;
               st      = dnsab_pkg::ST_SHORT_HEADER;
            end
         end
         dnsab_pkg::PH_NAME: begin
            words[n] = make_word(w.query_byte, 1'b1);
            n++;
            if (w.query_byte == 8'd0) begin
               phase     = dnsab_pkg::PH_TAIL;
               tail_left = dnsab_pkg::TailLen;
               st        = dnsab_pkg::ST_TRUNCATED;
            end else begin
               st = dnsab_pkg::ST_NO_TERMINATOR;
            end
         end
         dnsab_pkg::PH_TAIL: begin
            words[n] = make_word(w.query_byte, 1'b1);
            n++;
            if (tail_left != 3'd0)
               tail_left = tail_left - 3'd1;
            if (tail_left == 3'd0) begin
               phase = dnsab_pkg::PH_DONE;
               st    = dnsab_pkg::ST_OK;
            end else begin
               st = dnsab_pkg::ST_TRUNCATED;
            end
         end
         default: st = dnsab_pkg::ST_OK; // trailing bytes are dropped
      endcase

      if (w.last_byte) begin
         if (st == dnsab_pkg::ST_OK && w.name_found) begin
            answer = {NAME_POINTER, TYPE_A, ANSWER_CLASS, ttl_model, RDATA_LEN,
                      w.ipv4_addr};
            for (i = 15; i >= 0; i--) begin
               words[n] = make_word(answer[i*8 +: 8], 1'b1);
               n++;
            end
            answers_built++;
         end
         // Nothing else to say: close with a bare end marker.
         if (n == 0) begin
            words[0] = make_word(8'd0, 1'b0);
            n = 1;
         end
         words[n-1].end_of_response = 1'b1;
         words[n-1].status          = st;
         hdr_pos   = '0;
         phase     = dnsab_pkg::PH_HEADER;
         tail_left = '0;
      end

      for (i = 0; i < n; i++)
         pending_reply_words.push_back(words[i]);
   endfunction

   // Predict on every accepted query word.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         predict_reply(req_data);
   end

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("word %0d %s got %h want %h",
                                   words_checked, name, got, want));
   endtask

   // Compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin
      dnsab_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reply_words.size() == 0) begin
            report_mismatch($sformatf("unexpected response word %h", rsp_data));
         end else begin
            want = pending_reply_words.pop_front();
            check_field("out_byte", rsp_data.out_byte, want.out_byte);
            check_field("byte_valid", {7'd0, rsp_data.byte_valid}, {7'd0, want.byte_valid});
            check_field("end_of_response", {7'd0, rsp_data.end_of_response},
                        {7'd0, want.end_of_response});
            check_field("status", {6'd0, rsp_data.status}, {6'd0, want.status});
         end
         words_checked++;
      end
   end

   // Receiver backpressure: rotate a random stall pattern, reloaded now and
   // then; some reloads are all ones so there are stretches with no stalls.
   always @(posedge clock) begin
      if (!ready_stalls) begin
         rsp_ready <= 1'b1;
      end else begin
         if (pattern_age == 0) begin
            stall_pattern = 16'($urandom) | 16'h0001;
            if ($urandom_range(0, 3) == 0)
               stall_pattern = 16'hffff;
            pattern_age = $urandom_range(16, 80);
         end else begin
            pattern_age--;
         end
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         rsp_ready <= stall_pattern[0];
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Hand one query word to the block; insert a random gap between bursts.
   task automatic send_word(input dnsab_pkg::req_type w);
      if (sender_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0)
         burst_left--;
      words_sent++;
   endtask

   // Send the first len bytes of msg as one query; address and flag held.
   task automatic send_query(input byte_list_type msg, input int len,
                             input logic found, input logic [31:0] addr);
      dnsab_pkg::req_type w;
      int                 i;
      for (i = 0; i < len; i++) begin
         w.query_byte = msg[i];
         w.last_byte  = (i == len - 1);
         w.name_found = found;
         w.ipv4_addr  = addr;
         send_word(w);
      end
      queries_sent++;
   endtask

   // Hold off the sender until every predicted word has come back, then let
   // the pipeline settle so dropped words are out of the way too.
   task automatic wait_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reply_words.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the TTL register; only done with the block idle.
   task automatic write_ttl(input logic [31:0] value);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ttl_model = value;
      ttl_writes++;
   endtask

   // Build a random query: 35 in 100 well formed with random content, the rest
   // cut short at every stage, padded with trailing bytes, or pure noise.
   task automatic send_random_query();
      byte_list_type msg;
      int            name_len;
      int            full_len;
      int            len;
      int            pick;
      int            i;
      logic          found;
      logic [31:0]   addr;
      msg      = {};
      name_len = $urandom_range(0, 6);
      for (i = 0; i < HEADER_LEN; i++)
         msg.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < name_len; i++)
         msg.push_back(8'($urandom_range(1, 255)));
      msg.push_back(8'd0);
      for (i = 0; i < dnsab_pkg::TailLen + 3; i++) // tail plus room for trailing bytes
         msg.push_back(8'($urandom_range(0, 255)));
      full_len = HEADER_LEN + name_len + 1 + dnsab_pkg::TailLen;
      found    = ($urandom_range(0, 9) < 7);
      addr     = $urandom;
      pick     = $urandom_range(0, 99);
      if (pick < 35)
         len = full_len;
      else if (pick < 55)
         len = full_len + $urandom_range(1, 3);
      else if (pick < 62)
         len = $urandom_range(1, HEADER_LEN - 1);
      else if (pick < 67)
         len = HEADER_LEN;
      else if (pick < 75)
         len = (name_len == 0) ? HEADER_LEN :
               $urandom_range(HEADER_LEN + 1, HEADER_LEN + name_len);
      else if (pick < 82)
         len = HEADER_LEN + name_len + 1;
      else if (pick < 90)
         len = $urandom_range(full_len - 3, full_len - 1);
      else begin
         // Noise: zeros may land anywhere, terminator position is random.
         for (i = 0; i < msg.size(); i++)
            msg[i] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
         len = $urandom_range(1, msg.size());
      end
      send_query(msg, len, found, addr);
   endtask

   task automatic run_random_queries(input int count, input int drain_pct);
      int goal;
      goal = words_sent + count;
      while (words_sent < goal) begin
         send_random_query();
         if ($urandom_range(0, 99) < drain_pct)
            wait_drain();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // One-byte query and a query that ends on the last header byte.
   task automatic test_short_queries();
      byte_list_type msg;
      int            i;
      msg = {8'hff};
      send_query(msg, 1, 1'b1, 32'h0000_0000);
      msg = {8'h12, 8'h34};
      for (i = 2; i < HEADER_LEN; i++)
         msg.push_back(8'hff);
      send_query(msg, HEADER_LEN, 1'b0, 32'hffff_ffff);
      wait_drain();
   endtask

   // Root-name query that ends on the last tail byte: its final word gives the
   // longest reply to one query word, answer built with the reset TTL.
   task automatic test_full_answer();
      byte_list_type msg;
      int            i;
      msg = {};
      for (i = 0; i < HEADER_LEN; i++)
         msg.push_back(8'h00);
      msg.push_back(8'h00);
      msg = {msg, 8'h00, 8'h01, 8'h00, 8'h01};
      send_query(msg, msg.size(), 1'b1, 32'hffff_ffff);
      wait_drain();
   endtask

   // TTL at both extremes, first without and then with sender gaps and receiver stalls.
   task automatic test_ttl_extremes();
      write_ttl(32'h0000_0000);
      run_random_queries(40, 0);
      write_ttl(32'hffff_ffff);
      sender_gaps  = 1'b1;
      ready_stalls = 1'b1;
      run_random_queries(40, 0);
   endtask

   // Random TTLs under sender bursts and receiver stalls, with pauses that
   // let the block run dry between queries.
   task automatic test_backpressure();
      int phase_idx;
      sender_gaps  = 1'b1;
      ready_stalls = 1'b1;
      for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
         write_ttl($urandom);
         run_random_queries(45, 15);
      end
      write_ttl(dnsab_pkg::TtlReset);
      sender_gaps  = 1'b0;
      ready_stalls = 1'b0;
      run_random_queries(15, 0);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_queries();
      test_full_answer();
      test_ttl_extremes();
      test_backpressure();

      wait_drain();
      if (pending_reply_words.size() != 0)
         report_mismatch($sformatf("%0d response words never arrived",
                                   pending_reply_words.size()));

      $display("Covered %0d queries (%0d query words, %0d with an answer record),",
               queries_sent, words_sent, answers_built);
      $display("%0d TTL settings, %0d response words checked, %0d mismatches.",
               ttl_writes, words_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
